// ===== rtl/mbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the Mandelbrot escape-time evaluator.
// ----------------------------------------------------------------------------
package mbe_pkg;

    localparam int FRAC_BITS  = 60;
    localparam int DATA_W     = 64;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int HALF_W     = DATA_W / 2;
    localparam int STEP_W     = 63;
    localparam int COORD_W    = 12;
    localparam int COUNT_W    = 16;
    localparam int REG_IDX_W  = 3;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEFT_EDGE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOWER_EDGE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_REAL  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_IMAG  = 3'd4;

    localparam logic [COUNT_W-1:0] MAX_ITER_RESET = 16'd256;
    localparam logic [DATA_W-1:0]  EDGE_RESET     = 64'd0 - (64'd2 << FRAC_BITS);
    localparam logic [STEP_W-1:0]  STEP_RESET     = 63'd1 << (FRAC_BITS - 8);
    localparam logic [DATA_W-1:0]  FOUR           = 64'd4 << FRAC_BITS;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } mbe_mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mbe_mul_resp_t;

endpackage

// ===== rtl/mbe_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_mul
// 64x64 unsigned multiplier built from one 32x32 multiplier, four partial
// products accumulated over consecutive cycles.
// ----------------------------------------------------------------------------
module mbe_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mbe_pkg::mbe_mul_req_t req,
    output mbe_pkg::mbe_mul_resp_t resp
);
    import mbe_pkg::*;

    logic [DATA_W-1:0] a_reg;
    logic [DATA_W-1:0] b_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic [DATA_W-1:0] pp_reg;
    logic [1:0]        pp_sel_reg;
    logic              pp_valid_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              done_reg;

    logic [HALF_W-1:0] a_half;
    logic [HALF_W-1:0] b_half;
    logic [DATA_W-1:0] pp_next;
    logic [PROD_W-1:0] pp_shifted;

    always_comb
    begin
        a_half  = cnt_reg[0] ? a_reg[DATA_W-1:HALF_W] : a_reg[HALF_W-1:0];
        b_half  = cnt_reg[1] ? b_reg[DATA_W-1:HALF_W] : b_reg[HALF_W-1:0];
        pp_next = DATA_W'(a_half) * DATA_W'(b_half);
    end

    // weight of a partial product: 2^(32 * (a half + b half))
    always_comb
    begin
        unique case (pp_sel_reg)
            2'd0:    pp_shifted = {{DATA_W{1'b0}}, pp_reg};
            2'd3:    pp_shifted = {pp_reg, {DATA_W{1'b0}}};
            default: pp_shifted = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg        <= '0;
            b_reg        <= '0;
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            pp_reg       <= '0;
            pp_sel_reg   <= '0;
            pp_valid_reg <= 1'b0;
            acc_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                a_reg        <= req.a;
                b_reg        <= req.b;
                cnt_reg      <= '0;
                busy_reg     <= 1'b1;
                pp_valid_reg <= 1'b0;
                acc_reg      <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg < 3'd4)
                begin
                    pp_reg       <= pp_next;
                    pp_sel_reg   <= cnt_reg[1:0];
                    pp_valid_reg <= 1'b1;
                    cnt_reg      <= cnt_reg + 3'd1;
                end
                else
                begin
                    pp_valid_reg <= 1'b0;
                end
                if (pp_valid_reg)
                begin
                    acc_reg <= acc_reg + pp_shifted;
                    if (pp_sel_reg == 2'd3)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign resp.done    = done_reg;
    assign resp.product = acc_reg;

endmodule

// ===== rtl/mandelbrot_escape_time.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time count of one pixel, z = z^2 + c in signed Q4.60, with all
// 64x64 products done on one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Each iteration runs three 64x64 products (x*y, x^2, y^2) on the shared
// 32x32 multiplier, plus the update states S_UPD1, S_UPD2 and S_MAG.
// Throughput: one item at a time; in_ready is low from accept until the
// result is moved to the output register, which may still be waiting.
// Reset: async active low; config registers return to their defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mbe_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [mbe_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mbe_pkg::COORD_W-1:0]   column,
    input  logic [mbe_pkg::COORD_W-1:0]   pixel_row,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mbe_pkg::COORD_W-1:0]   out_column,
    output logic [mbe_pkg::COORD_W-1:0]   out_row,
    output logic [mbe_pkg::COUNT_W-1:0]   iteration_count
);
    import mbe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_MUL, S_POST1, S_POST2, S_UPD1, S_UPD2, S_MAG
    } state_t;

    typedef enum logic [2:0] {
        OP_CRE, OP_CIM, OP_XY, OP_SQX, OP_SQY
    } op_t;

    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // configuration
    logic [COUNT_W-1:0] max_iter_reg;
    logic [DATA_W-1:0]  left_edge_reg;
    logic [DATA_W-1:0]  lower_edge_reg;
    logic [STEP_W-1:0]  step_real_reg;
    logic [STEP_W-1:0]  step_imag_reg;

    // sequencer and datapath
    state_t              state_reg;
    op_t                 op_reg;
    logic                done_pending_reg;
    logic [COORD_W-1:0]  col_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [COUNT_W-1:0]  limit_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [DATA_W-1:0]   c_re_reg;
    logic [DATA_W-1:0]   c_im_reg;
    logic [DATA_W-1:0]   x_reg;
    logic [DATA_W-1:0]   y_reg;
    logic [DATA_W-1:0]   xx_reg;
    logic [DATA_W-1:0]   yy_reg;
    logic [DATA_W-1:0]   t_reg;
    logic                neg_reg;
    logic signed [PROD_W-1:0] v_reg;

    logic                out_valid_reg;
    logic [COORD_W-1:0]  out_column_reg;
    logic [COORD_W-1:0]  out_row_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    mbe_mul_req_t        mul_req;
    mbe_mul_resp_t       mul_resp;

    logic [PROD_W-1:0]   post_value;
    logic [PROD_W-1:0]   shifted;
    logic [DATA_W-1:0]   clamped;
    logic [DATA_W-1:0]   mag;
    logic                escape;
    logic [COUNT_W-1:0]  count_next;
    logic                out_free;
    logic                out_load;

    function automatic logic [DATA_W-1:0] abs64(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = v[DATA_W-1] ? ({DATA_W{1'b0}} - v) : v;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] clamp128(input logic [PROD_W-1:0] s);
        logic [DATA_W-1:0] r;
        if (s[PROD_W-1:DATA_W-1] == {(DATA_W+1){s[DATA_W-1]}})
            r = s[DATA_W-1:0];
        else
            r = s[PROD_W-1] ? SAT_MIN : SAT_MAX;
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] s;
        s = a + b;
        if ((a[DATA_W-1] == b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]))
            s = a[DATA_W-1] ? SAT_MIN : SAT_MAX;
        return s;
    endfunction

    function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                  input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] s;
        s = a - b;
        if ((a[DATA_W-1] != b[DATA_W-1]) && (s[DATA_W-1] != a[DATA_W-1]))
            s = a[DATA_W-1] ? SAT_MIN : SAT_MAX;
        return s;
    endfunction

    mbe_mul u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (mul_req),
        .resp (mul_resp)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg   <= MAX_ITER_RESET;
            left_edge_reg  <= EDGE_RESET;
            lower_edge_reg <= EDGE_RESET;
            step_real_reg  <= STEP_RESET;
            step_imag_reg  <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_ITER:   max_iter_reg   <= cfg_data[COUNT_W-1:0];
                REG_LEFT_EDGE:  left_edge_reg  <= cfg_data;
                REG_LOWER_EDGE: lower_edge_reg <= cfg_data;
                REG_STEP_REAL:  step_real_reg  <= cfg_data[STEP_W-1:0];
                REG_STEP_IMAG:  step_imag_reg  <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // operands for the shared multiplier, magnitudes only
    always_comb
    begin
        mul_req.start = (state_reg == S_ISSUE);
        unique case (op_reg)
            OP_CRE:
            begin
                mul_req.a = {{(DATA_W-COORD_W){1'b0}}, col_reg};
                mul_req.b = {1'b0, step_real_reg};
            end
            OP_CIM:
            begin
                mul_req.a = {{(DATA_W-COORD_W){1'b0}}, row_reg};
                mul_req.b = {1'b0, step_imag_reg};
            end
            OP_XY:
            begin
                mul_req.a = abs64(x_reg);
                mul_req.b = abs64(y_reg);
            end
            OP_SQX:
            begin
                mul_req.a = abs64(x_reg);
                mul_req.b = abs64(x_reg);
            end
            OP_SQY:
            begin
                mul_req.a = abs64(y_reg);
                mul_req.b = abs64(y_reg);
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    // product post-processing: sign / offset, then scale and saturate
    always_comb
    begin
        unique case (op_reg)
            OP_CRE:  post_value = mul_resp.product
                                  + {{DATA_W{left_edge_reg[DATA_W-1]}}, left_edge_reg};
            OP_CIM:  post_value = mul_resp.product
                                  + {{DATA_W{lower_edge_reg[DATA_W-1]}}, lower_edge_reg};
            OP_XY:   post_value = neg_reg ? ({PROD_W{1'b0}} - mul_resp.product)
                                          : mul_resp.product;
            default: post_value = mul_resp.product;
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_XY:         shifted = PROD_W'(v_reg >>> (FRAC_BITS - 1));
            OP_SQX, OP_SQY: shifted = PROD_W'(v_reg >>> FRAC_BITS);
            default:       shifted = v_reg;
        endcase
        clamped = clamp128(shifted);
    end

    // both squares are non-negative, so the sum is too
    assign mag        = sat_add(xx_reg, yy_reg);
    assign escape     = $signed(mag) >= $signed(FOUR);
    assign count_next = count_reg + 16'd1;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_load   = (state_reg == S_MAG) && done_pending_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= OP_CRE;
            done_pending_reg <= 1'b0;
            col_reg          <= '0;
            row_reg          <= '0;
            limit_reg        <= '0;
            count_reg        <= '0;
            c_re_reg         <= '0;
            c_im_reg         <= '0;
            x_reg            <= '0;
            y_reg            <= '0;
            xx_reg           <= '0;
            yy_reg           <= '0;
            t_reg            <= '0;
            neg_reg          <= 1'b0;
            v_reg            <= '0;
            out_valid_reg    <= 1'b0;
            out_column_reg   <= '0;
            out_row_reg      <= '0;
            count_out_reg    <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        col_reg   <= column;
                        row_reg   <= pixel_row;
                        // a zero limit behaves as one
                        limit_reg <= (max_iter_reg == '0) ? 16'd1 : max_iter_reg;
                        count_reg <= '0;
                        x_reg     <= '0;
                        y_reg     <= '0;
                        xx_reg    <= '0;
                        yy_reg    <= '0;
                        op_reg    <= OP_CRE;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE:
                begin
                    neg_reg   <= (op_reg == OP_XY) && (x_reg[DATA_W-1] ^ y_reg[DATA_W-1]);
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (mul_resp.done)
                        state_reg <= S_POST1;
                end
                S_POST1:
                begin
                    v_reg     <= post_value;
                    state_reg <= S_POST2;
                end
                S_POST2:
                begin
                    unique case (op_reg)
                        OP_CRE:
                        begin
                            c_re_reg  <= clamped;
                            op_reg    <= OP_CIM;
                            state_reg <= S_ISSUE;
                        end
                        OP_CIM:
                        begin
                            c_im_reg  <= clamped;
                            op_reg    <= OP_XY;
                            state_reg <= S_ISSUE;
                        end
                        OP_XY:
                        begin
                            t_reg     <= clamped;
                            state_reg <= S_UPD1;
                        end
                        OP_SQX:
                        begin
                            xx_reg    <= clamped;
                            op_reg    <= OP_SQY;
                            state_reg <= S_ISSUE;
                        end
                        OP_SQY:
                        begin
                            yy_reg    <= clamped;
                            state_reg <= S_MAG;
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end
                S_UPD1:
                begin
                    // xx_reg holds xx - yy until the new squares arrive
                    xx_reg    <= sat_sub(xx_reg, yy_reg);
                    y_reg     <= sat_add(t_reg, c_im_reg);
                    state_reg <= S_UPD2;
                end
                S_UPD2:
                begin
                    x_reg     <= sat_add(xx_reg, c_re_reg);
                    op_reg    <= OP_SQX;
                    state_reg <= S_ISSUE;
                end
                S_MAG:
                begin
                    if (done_pending_reg)
                    begin
                        // waiting for the output register to free up
                        if (out_free)
                        begin
                            out_column_reg   <= col_reg;
                            out_row_reg      <= row_reg;
                            count_out_reg    <= count_reg;
                            done_pending_reg <= 1'b0;
                            state_reg        <= S_IDLE;
                        end
                    end
                    else
                    begin
                        count_reg <= count_next;
                        if (escape || (count_next >= limit_reg))
                        begin
                            done_pending_reg <= 1'b1;
                        end
                        else
                        begin
                            op_reg    <= OP_XY;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign out_column      = out_column_reg;
    assign out_row         = out_row_reg;
    assign iteration_count = count_out_reg;

endmodule

// ===== rtl/mbe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks for the escape-time evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [mbe_pkg::COORD_W-1:0]   column,
    input logic [mbe_pkg::COORD_W-1:0]   pixel_row,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mbe_pkg::COORD_W-1:0]   out_column,
    input logic [mbe_pkg::COORD_W-1:0]   out_row,
    input logic [mbe_pkg::COUNT_W-1:0]   iteration_count
);
    import mbe_pkg::*;

    logic [COORD_W-1:0] last_col_reg;
    logic [COORD_W-1:0] last_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= '0;
            last_row_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            last_col_reg <= column;
            last_row_reg <= pixel_row;
        end
    end

    // a result stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(iteration_count))
        else $error("result dropped or changed while stalled");

    // the count is never zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> iteration_count != '0)
        else $error("zero iteration count");

    // one item at a time: no accept right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted while busy");

    // a fresh result carries the coordinates of the last accepted item
    a_coords: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> out_column == last_col_reg && out_row == last_row_reg)
        else $error("result coordinates do not match accepted item");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);
